// ----- design/pcf_pkg.sv -----
// Shared types, codes and constants of the path curve flattener.
package pcf_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_DEPTH_DEF   = 6;
  localparam int DEPTH_W         = 3;
  localparam int CMD_W           = 3;
  localparam int KIND_W          = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = 3'd6;

  localparam int Q16_SHIFT   = 16;
  localparam int UNIT_SHIFT  = 24;
  localparam int UNIT_ONE    = 65536;
  localparam int K_NUM_SHIFT = 32;
  localparam int K_DEN_SHIFT = 17;
  localparam int FOUR_SHIFT  = 34;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE  = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_CONIC = 3'd2,
    CMD_ARC   = 3'd3,
    CMD_CUBIC = 3'd4,
    CMD_CLOSE = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic done;
    logic degen;
  } pcf_arc_stat_t;

endpackage

// ----- design/pcf_if.sv -----
// Command and segment stream interfaces of the path curve flattener.
interface pcf_cmd_if import pcf_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic signed [CW-1:0] x1;
  logic signed [CW-1:0] y1;
  logic signed [CW-1:0] x2;
  logic signed [CW-1:0] y2;
  logic signed [CW-1:0] x3;
  logic signed [CW-1:0] y3;

  modport source (output valid, command, x1, y1, x2, y2, x3, y3, input ready);
  modport sink (input valid, command, x1, y1, x2, y2, x3, y3, output ready);
endinterface

interface pcf_seg_if import pcf_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic                 last;

  modport source (output valid, kind, x, y, last, input ready);
  modport sink (input valid, kind, x, y, last, output ready);
endinterface

// ----- design/path_curve_flattener.sv -----
// Path curve flattener top level: command sequencer, split stack memory, config port.
// Move, line, close, error: one transfer, emitted from dispatch once the output register is free.
// Conic/cubic: a dispatch state, a node state per split node, node and leaf per segment, a load per stack reload.
// Arc node: computed by the bitwise root and restoring divide in the arc engine;
// next command taken after last result.
// Reset (rst_n low, synchronous) clears current point, subpath start, depth and sets max_depth 6.
module path_curve_flattener import pcf_pkg::*; #(
  parameter int MAX_DEPTH   = MAX_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pcf_cmd_if.sink               in_cmd,
  pcf_seg_if.source             out_seg,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW   = COORD_WIDTH;
  localparam int IW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ROWW = 6 * CW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_NODE = 6'b000100,
    S_ARC  = 6'b001000,
    S_LEAF = 6'b010000,
    S_LOAD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic signed [CW-1:0] pax_r, pay_r, pbx_r, pby_r, ptx_r, pty_r;
  logic signed [CW-1:0] pax_nxt, pay_nxt, pbx_nxt, pby_nxt, ptx_nxt, pty_nxt;
  logic signed [CW-1:0] curx_r, cury_r, subx_r, suby_r;
  logic signed [CW-1:0] curx_nxt, cury_nxt, subx_nxt, suby_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [MAX_DEPTH-1:0] pend_r, pend_nxt;
  logic [DEPTH_W-1:0]   maxd_r;
  logic                 ov_r, ov_nxt;
  logic [KIND_W-1:0]    okind_r, okind_nxt;
  logic signed [CW-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic                 olast_r, olast_nxt;

  logic [ROWW-1:0] mem [MAX_DEPTH];
  logic [ROWW-1:0] rd_r;
  logic [ROWW-1:0] wrow;
  logic            mem_we, mem_re;
  logic [IW-1:0]   hi_idx;

  logic               out_free, emit, e_last, arc_start, at_cap, is_cubic;
  kind_t              e_kind;
  logic signed [CW-1:0] e_x, e_y;
  logic [DEPTH_W-1:0] cap;

  logic signed [CW-1:0] ohx, ohy, cmx, cmy, chx, chy, csx, csy;
  logic signed [CW-1:0] kcx, kcy, p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y, kmx, kmy;
  logic                 flat;

  pcf_arc_stat_t        arc_stat;
  logic signed [CW-1:0] amx, amy, apx, apy, aqx, aqy;

  function automatic logic signed [CW-1:0] mid(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    return s[CW:1];
  endfunction

  pcf_arc #(.CW(CW)) u_arc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (arc_start),
    .sx    (curx_r),
    .sy    (cury_r),
    .cx    (pax_r),
    .cy    (pay_r),
    .tx    (ptx_r),
    .ty    (pty_r),
    .stat  (arc_stat),
    .mx    (amx),
    .my    (amy),
    .px    (apx),
    .py    (apy),
    .qx    (aqx),
    .qy    (aqy)
  );

  assign cap      = (32'(maxd_r) < MAX_DEPTH) ? maxd_r : DEPTH_W'(MAX_DEPTH);
  assign at_cap   = depth_r >= cap;
  assign out_free = !ov_r || out_seg.ready;
  assign is_cubic = (cmd_r == CMD_CUBIC);

  assign ohx = mid(curx_r, ptx_r);
  assign ohy = mid(cury_r, pty_r);
  assign cmx = mid(ohx, pax_r);
  assign cmy = mid(ohy, pay_r);
  assign chx = mid(pax_r, ptx_r);
  assign chy = mid(pay_r, pty_r);
  assign csx = mid(curx_r, pax_r);
  assign csy = mid(cury_r, pay_r);
  assign kcx = mid(pax_r, pbx_r);
  assign kcy = mid(pay_r, pby_r);
  assign p1x = csx;
  assign p1y = csy;
  assign q1x = mid(ptx_r, pbx_r);
  assign q1y = mid(pty_r, pby_r);
  assign p2x = mid(p1x, kcx);
  assign p2y = mid(p1y, kcy);
  assign q2x = mid(q1x, kcx);
  assign q2y = mid(q1y, kcy);
  assign kmx = mid(p2x, q2x);
  assign kmy = mid(p2y, q2y);
  assign flat = is_cubic ? (kmx == ohx && kmy == ohy) : (cmx == ohx && cmy == ohy);

  always_comb begin
    hi_idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (pend_r[i]) begin
        hi_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    pax_nxt   = pax_r;
    pay_nxt   = pay_r;
    pbx_nxt   = pbx_r;
    pby_nxt   = pby_r;
    ptx_nxt   = ptx_r;
    pty_nxt   = pty_r;
    curx_nxt  = curx_r;
    cury_nxt  = cury_r;
    subx_nxt  = subx_r;
    suby_nxt  = suby_r;
    depth_nxt = depth_r;
    pend_nxt  = pend_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wrow      = {chx, chy, pbx_r, pby_r, ptx_r, pty_r};
    arc_start = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_LINE;
    e_x       = ptx_r;
    e_y       = pty_r;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_cmd.valid) begin
          cmd_nxt   = in_cmd.command;
          pax_nxt   = in_cmd.x1;
          pay_nxt   = in_cmd.y1;
          pbx_nxt   = in_cmd.x2;
          pby_nxt   = in_cmd.y2;
          ptx_nxt   = (in_cmd.command == CMD_CUBIC) ? in_cmd.x3 : in_cmd.x2;
          pty_nxt   = (in_cmd.command == CMD_CUBIC) ? in_cmd.y3 : in_cmd.y2;
          depth_nxt = '0;
          pend_nxt  = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_r)
          CMD_MOVE: begin
            if (out_free) begin
              emit      = 1'b1;
              e_kind    = KIND_OPEN;
              e_x       = pax_r;
              e_y       = pay_r;
              curx_nxt  = pax_r;
              cury_nxt  = pay_r;
              subx_nxt  = pax_r;
              suby_nxt  = pay_r;
              state_nxt = S_IDLE;
            end
          end
          CMD_LINE: begin
            if (out_free) begin
              emit      = 1'b1;
              e_x       = pax_r;
              e_y       = pay_r;
              curx_nxt  = pax_r;
              cury_nxt  = pay_r;
              state_nxt = S_IDLE;
            end
          end
          CMD_CLOSE: begin
            if (out_free) begin
              emit      = 1'b1;
              e_kind    = KIND_CLOSE;
              e_x       = subx_r;
              e_y       = suby_r;
              curx_nxt  = subx_r;
              cury_nxt  = suby_r;
              state_nxt = S_IDLE;
            end
          end
          CMD_CONIC, CMD_ARC, CMD_CUBIC: begin
            state_nxt = S_NODE;
          end
          default: begin
            if (out_free) begin
              emit      = 1'b1;
              e_kind    = KIND_ERROR;
              e_x       = '0;
              e_y       = '0;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_NODE: begin
        if (cmd_r == CMD_ARC) begin
          if (at_cap) begin
            state_nxt = S_LEAF;
          end else begin
            arc_start = 1'b1;
            state_nxt = S_ARC;
          end
        end else if (at_cap || flat) begin
          state_nxt = S_LEAF;
        end else begin
          mem_we = 1'b1;
          pend_nxt[depth_r[IW-1:0]] = 1'b1;
          depth_nxt = depth_r + DEPTH_W'(1);
          if (is_cubic) begin
            wrow    = {q2x, q2y, q1x, q1y, ptx_r, pty_r};
            pax_nxt = p1x;
            pay_nxt = p1y;
            pbx_nxt = p2x;
            pby_nxt = p2y;
            ptx_nxt = kmx;
            pty_nxt = kmy;
          end else begin
            pax_nxt = csx;
            pay_nxt = csy;
            ptx_nxt = cmx;
            pty_nxt = cmy;
          end
        end
      end
      S_ARC: begin
        if (arc_stat.done) begin
          if (arc_stat.degen || (amx == ohx && amy == ohy)) begin
            state_nxt = S_LEAF;
          end else begin
            mem_we  = 1'b1;
            wrow    = {aqx, aqy, pbx_r, pby_r, ptx_r, pty_r};
            pend_nxt[depth_r[IW-1:0]] = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
            pax_nxt   = apx;
            pay_nxt   = apy;
            ptx_nxt   = amx;
            pty_nxt   = amy;
            state_nxt = S_NODE;
          end
        end
      end
      S_LEAF: begin
        if (out_free) begin
          emit     = 1'b1;
          e_last   = (pend_r == '0);
          curx_nxt = ptx_r;
          cury_nxt = pty_r;
          if (pend_r != '0) begin
            mem_re            = 1'b1;
            pend_nxt[hi_idx]  = 1'b0;
            depth_nxt         = DEPTH_W'(hi_idx) + DEPTH_W'(1);
            state_nxt         = S_LOAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        pax_nxt   = rd_r[6*CW-1 -: CW];
        pay_nxt   = rd_r[5*CW-1 -: CW];
        pbx_nxt   = rd_r[4*CW-1 -: CW];
        pby_nxt   = rd_r[3*CW-1 -: CW];
        ptx_nxt   = rd_r[2*CW-1 -: CW];
        pty_nxt   = rd_r[CW-1:0];
        state_nxt = S_NODE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ov_nxt    = ov_r;
    okind_nxt = okind_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      okind_nxt = e_kind;
      ox_nxt    = e_x;
      oy_nxt    = e_y;
      olast_nxt = e_last;
    end else if (out_seg.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      curx_r  <= '0;
      cury_r  <= '0;
      subx_r  <= '0;
      suby_r  <= '0;
      depth_r <= '0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
      maxd_r  <= MAX_DEPTH_RESET;
    end else begin
      state_r <= state_nxt;
      curx_r  <= curx_nxt;
      cury_r  <= cury_nxt;
      subx_r  <= subx_nxt;
      suby_r  <= suby_nxt;
      depth_r <= depth_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      if (psel && penable && pwrite && paddr == REG_MAX_DEPTH) begin
        maxd_r <= pwdata[DEPTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    pax_r   <= pax_nxt;
    pay_r   <= pay_nxt;
    pbx_r   <= pbx_nxt;
    pby_r   <= pby_nxt;
    ptx_r   <= ptx_nxt;
    pty_r   <= pty_nxt;
    okind_r <= okind_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[depth_r[IW-1:0]] <= wrow;
    end
    if (mem_re) begin
      rd_r <= mem[hi_idx];
    end
  end

  assign in_cmd.ready  = (state_r == S_IDLE);
  assign out_seg.valid = ov_r;
  assign out_seg.kind  = okind_r;
  assign out_seg.x     = ox_r;
  assign out_seg.y     = oy_r;
  assign out_seg.last  = olast_r;
  assign pready        = 1'b1;
  assign prdata        = (paddr == REG_MAX_DEPTH) ? CFG_DATA_W'(maxd_r) : '0;

  a_push_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (depth_r < cap))
    else $error("split stack pushed at or beyond the depth cap");
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> $past(mem_re))
    else $error("stack reload without a read");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pend_r == '0))
    else $error("pending halves left when command finished");
  a_arc_start: assert property (@(posedge clk) disable iff (!rst_n)
    arc_start |=> (state_r == S_ARC))
    else $error("arc engine started outside the arc wait");

endmodule

// ----- design/pcf_arc.sv -----
// Arc split engine: radius lengths, unit vectors, factor and split points.
module pcf_arc import pcf_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CW-1:0] sx,
  input  logic signed [CW-1:0] sy,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] tx,
  input  logic signed [CW-1:0] ty,
  output pcf_arc_stat_t        stat,
  output logic signed [CW-1:0] mx,
  output logic signed [CW-1:0] my,
  output logic signed [CW-1:0] px,
  output logic signed [CW-1:0] py,
  output logic signed [CW-1:0] qx,
  output logic signed [CW-1:0] qy
);

  localparam int DW1 = CW + 1;
  localparam int MW  = (CW + 2 > 19) ? CW + 2 : 19;
  localparam int PW  = 2 * MW;
  localparam int RW  = 2 * CW + 20;
  localparam int RH  = RW / 2;
  localparam int ND  = (CW + UNIT_SHIFT + 1 > 33) ? CW + UNIT_SHIFT + 1 : 33;
  localparam int DV  = (RH + 1 > 19) ? RH + 1 : 19;
  localparam int RCW = $clog2(RH + 1);
  localparam int DCW = $clog2(ND + 1);
  localparam int FW  = PW + 1;
  localparam int UW  = 18;
  localparam int KW  = 17;

  typedef enum logic [9:0] {
    AS_IDLE = 10'b0000000001,
    AS_SQ0  = 10'b0000000010,
    AS_SQ1  = 10'b0000000100,
    AS_ROOT = 10'b0000001000,
    AS_DIV  = 10'b0000010000,
    AS_VV0  = 10'b0000100000,
    AS_VV1  = 10'b0001000000,
    AS_FMUL = 10'b0010000000,
    AS_FADD = 10'b0100000000,
    AS_DONE = 10'b1000000000
  } arc_state_t;

  typedef enum logic [2:0] {
    J_LEN = 3'd0,
    J_RT  = 3'd1,
    J_UX  = 3'd2,
    J_UY  = 3'd3,
    J_K   = 3'd4
  } arc_job_t;

  arc_state_t state_r;
  arc_job_t   job_r;

  logic signed [DW1-1:0] ax_r, ay_r, bx_r, by_r;
  logic                  sel_b_r;
  logic                  degen_r;
  logic signed [UW-1:0]  uax_r, uay_r, ubx_r, uby_r;
  logic signed [PW-1:0]  acc_r;
  logic signed [PW-1:0]  prod_r;
  logic [RW-1:0]         rn_r, rr_r, rb_r;
  logic [RCW-1:0]        rcnt_r;
  logic [ND-1:0]         dn_r, dq_r;
  logic [DV:0]           drem_r;
  logic [DV-1:0]         dden_r;
  logic [DCW-1:0]        dcnt_r;
  logic                  dneg_r;
  logic [KW-1:0]         k_r;
  logic [2:0]            fidx_r;
  logic signed [CW-1:0]  mx_r, my_r, px_r, py_r, qx_r, qy_r;

  logic signed [DW1-1:0] vxw, vyw;
  logic [DW1-1:0]        absx, absy;
  logic signed [18:0]    vx_s, vy_s;
  logic signed [MW-1:0]  ma, mb;
  logic signed [PW-1:0]  prod, sqsum;
  logic [KW:0]           kk_u;
  logic signed [DW1:0]   sumx, sumy;
  logic signed [MW-1:0]  fv;
  logic signed [CW-1:0]  fc;
  logic [RW-1:0]         rad_sq, rad_vv, vvu, four, rsum, rr_step, rn_step;
  logic                  rge;
  logic [DV:0]           dt;
  logic                  dge;
  logic [ND-1:0]         q_fin, qc;
  logic signed [UW-1:0]  upos, unit_v;
  logic signed [FW-1:0]  fsum, fmag, fq, ftv, fhi, flo;
  logic signed [CW-1:0]  fres;
  logic                  za, zb;

  assign za = (sx == cx) && (sy == cy);
  assign zb = (tx == cx) && (ty == cy);

  assign vxw  = sel_b_r ? bx_r : ax_r;
  assign vyw  = sel_b_r ? by_r : ay_r;
  assign absx = vxw[DW1-1] ? DW1'(-vxw) : DW1'(vxw);
  assign absy = vyw[DW1-1] ? DW1'(-vyw) : DW1'(vyw);
  assign vx_s = 19'(uax_r) + 19'(ubx_r);
  assign vy_s = 19'(uay_r) + 19'(uby_r);
  assign sumx = (DW1+1)'(ax_r) + (DW1+1)'(bx_r);
  assign sumy = (DW1+1)'(ay_r) + (DW1+1)'(by_r);
  assign kk_u = (fidx_r < 3'd2) ? {1'b0, k_r} : {k_r, 1'b0};

  always_comb begin
    case (fidx_r)
      3'd0:    fv = MW'(sumx);
      3'd1:    fv = MW'(sumy);
      3'd2:    fv = MW'(ax_r);
      3'd3:    fv = MW'(ay_r);
      3'd4:    fv = MW'(bx_r);
      default: fv = MW'(by_r);
    endcase
    fc = fidx_r[0] ? cy : cx;
  end

  always_comb begin
    case (state_r)
      AS_SQ0: begin
        ma = MW'(vxw);
        mb = MW'(vxw);
      end
      AS_SQ1: begin
        ma = MW'(vyw);
        mb = MW'(vyw);
      end
      AS_VV0: begin
        ma = MW'(vx_s);
        mb = MW'(vx_s);
      end
      AS_VV1: begin
        ma = MW'(vy_s);
        mb = MW'(vy_s);
      end
      AS_FMUL: begin
        ma = MW'(kk_u);
        mb = fv;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign sqsum  = acc_r + prod;
  assign rad_sq = RW'(sqsum) << Q16_SHIFT;
  assign vvu    = RW'(sqsum);
  assign four   = RW'(1) << FOUR_SHIFT;
  assign rad_vv = (vvu >= four) ? '0 : four - vvu;

  assign rsum    = rr_r + rb_r;
  assign rge     = rn_r >= rsum;
  assign rr_step = rge ? (rr_r >> 1) + rb_r : rr_r >> 1;
  assign rn_step = rge ? rn_r - rsum : rn_r;

  assign dt    = {drem_r[DV-1:0], dn_r[ND-1]};
  assign dge   = dt >= {1'b0, dden_r};
  assign q_fin = {dq_r[ND-2:0], dge};
  assign qc    = (q_fin > ND'(UNIT_ONE)) ? ND'(UNIT_ONE) : q_fin;
  assign upos  = UW'(qc);
  assign unit_v = dneg_r ? -upos : upos;

  assign fhi  = (FW'(1) <<< (CW - 1)) - FW'(1);
  assign flo  = -fhi - FW'(1);
  assign fsum = (FW'(fc) <<< Q16_SHIFT) + FW'(prod_r);
  assign fmag = fsum[FW-1] ? -fsum : fsum;
  assign fq   = fmag >>> Q16_SHIFT;
  assign ftv  = fsum[FW-1] ? -fq : fq;
  assign fres = (ftv > fhi) ? fhi[CW-1:0] : ((ftv < flo) ? flo[CW-1:0] : ftv[CW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AS_IDLE;
      job_r   <= J_LEN;
      sel_b_r <= 1'b0;
      degen_r <= 1'b0;
      rcnt_r  <= '0;
      dcnt_r  <= '0;
      fidx_r  <= '0;
    end else begin
      case (state_r)
        AS_IDLE: begin
          if (start) begin
            ax_r    <= DW1'(sx) - DW1'(cx);
            ay_r    <= DW1'(sy) - DW1'(cy);
            bx_r    <= DW1'(tx) - DW1'(cx);
            by_r    <= DW1'(ty) - DW1'(cy);
            sel_b_r <= 1'b0;
            degen_r <= za || zb;
            state_r <= (za || zb) ? AS_DONE : AS_SQ0;
          end
        end
        AS_SQ0: begin
          acc_r   <= prod;
          state_r <= AS_SQ1;
        end
        AS_SQ1: begin
          rn_r    <= rad_sq;
          rr_r    <= '0;
          rb_r    <= RW'(1) << (RW - 2);
          rcnt_r  <= '0;
          job_r   <= J_LEN;
          state_r <= AS_ROOT;
        end
        AS_ROOT: begin
          rn_r   <= rn_step;
          rr_r   <= rr_step;
          rb_r   <= rb_r >> 2;
          rcnt_r <= rcnt_r + RCW'(1);
          if (rcnt_r == RCW'(RH - 1)) begin
            drem_r <= '0;
            dq_r   <= '0;
            dcnt_r <= '0;
            if (job_r == J_LEN) begin
              dn_r   <= ND'(absx) << UNIT_SHIFT;
              dden_r <= DV'(rr_step[RH-1:0]);
              dneg_r <= vxw[DW1-1];
              job_r  <= J_UX;
            end else begin
              dn_r   <= ND'(1) << K_NUM_SHIFT;
              dden_r <= (DV'(1) << K_DEN_SHIFT) + DV'(rr_step[RH-1:0]);
              dneg_r <= 1'b0;
              job_r  <= J_K;
            end
            state_r <= AS_DIV;
          end
        end
        AS_DIV: begin
          drem_r <= dge ? dt - {1'b0, dden_r} : dt;
          dn_r   <= dn_r << 1;
          dq_r   <= q_fin;
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(ND - 1)) begin
            drem_r <= '0;
            dq_r   <= '0;
            dcnt_r <= '0;
            case (job_r)
              J_UX: begin
                if (sel_b_r) begin
                  ubx_r <= unit_v;
                end else begin
                  uax_r <= unit_v;
                end
                dn_r   <= ND'(absy) << UNIT_SHIFT;
                dneg_r <= vyw[DW1-1];
                job_r  <= J_UY;
              end
              J_UY: begin
                if (sel_b_r) begin
                  uby_r   <= unit_v;
                  state_r <= AS_VV0;
                end else begin
                  uay_r   <= unit_v;
                  sel_b_r <= 1'b1;
                  state_r <= AS_SQ0;
                end
              end
              default: begin
                k_r     <= q_fin[KW-1:0];
                fidx_r  <= '0;
                state_r <= AS_FMUL;
              end
            endcase
          end
        end
        AS_VV0: begin
          acc_r   <= prod;
          state_r <= AS_VV1;
        end
        AS_VV1: begin
          if (sqsum == '0) begin
            degen_r <= 1'b1;
            state_r <= AS_DONE;
          end else begin
            rn_r    <= rad_vv;
            rr_r    <= '0;
            rb_r    <= RW'(1) << (RW - 2);
            rcnt_r  <= '0;
            job_r   <= J_RT;
            state_r <= AS_ROOT;
          end
        end
        AS_FMUL: begin
          prod_r  <= prod;
          state_r <= AS_FADD;
        end
        AS_FADD: begin
          case (fidx_r)
            3'd0:    mx_r <= fres;
            3'd1:    my_r <= fres;
            3'd2:    px_r <= fres;
            3'd3:    py_r <= fres;
            3'd4:    qx_r <= fres;
            default: qy_r <= fres;
          endcase
          fidx_r  <= fidx_r + 3'd1;
          state_r <= (fidx_r == 3'd5) ? AS_DONE : AS_FMUL;
        end
        AS_DONE: begin
          state_r <= AS_IDLE;
        end
        default: begin
          state_r <= AS_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = (state_r == AS_DONE);
  assign stat.degen = degen_r;
  assign mx = mx_r;
  assign my = my_r;
  assign px = px_r;
  assign py = py_r;
  assign qx = qx_r;
  assign qy = qy_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != AS_IDLE) |=> !(state_r == AS_IDLE && $past(state_r) != AS_DONE))
    else $error("arc engine returned to idle without finishing");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == AS_DIV) |-> (dden_r != '0))
    else $error("arc divide with zero divisor");
  a_fix_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == AS_FMUL || state_r == AS_FADD) |-> (fidx_r < 3'd6))
    else $error("arc point index out of range");

endmodule

// ----- tb/path_curve_flattener_test.sv -----
// Testbench for the path curve flattener: table-driven and random commands against a predictor.
`timescale 1ns / 1ps

module path_curve_flattener_test import pcf_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
  localparam int SEG_CAP = 64;
  localparam int DEPTH_CAP = MAX_DEPTH_DEF;
  localparam int QUIET_LIMIT = 60000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic last;
  } seg_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    shortint x1, y1, x2, y2, x3, y3;
    bit typed;
    logic [KIND_W-1:0] kind;
    shortint ex, ey;
  } row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pcf_cmd_if cmd_bus ();
  pcf_seg_if seg_bus ();

  path_curve_flattener DUT (
    .clk(clk), .rst_n(rst_n), .in_cmd(cmd_bus), .out_seg(seg_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  seg_t seg_expect[$];
  seg_t cmd_segs[$];
  longint pen_x, pen_y, sub_x, sub_y;
  int unsigned depth_reg;
  int unsigned split_cap;
  int fail_count;
  int cmd_count;
  int seg_count;
  int quiet;
  int sender_idle_pct;
  int sink_stall_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic longint halve(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint clip16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint quot_trunc(longint num, longint unsigned den);
    longint unsigned mag;
    if (den == 0) return 0;
    mag = num < 0 ? longint'(-num) : num;
    return num < 0 ? -longint'(mag / den) : longint'(mag / den);
  endfunction

  function automatic void push_seg(logic [KIND_W-1:0] kind, longint x, longint y);
    seg_t s;
    if (cmd_segs.size() >= SEG_CAP) return;
    s.kind = kind;
    s.x = x[15:0];
    s.y = y[15:0];
    s.last = 1'b0;
    cmd_segs.push_back(s);
  endfunction

  function automatic void draw_to(longint x, longint y);
    push_seg(KIND_LINE, x, y);
    pen_x = x;
    pen_y = y;
  endfunction

  function automatic void split_conic(int unsigned d, longint cx, longint cy,
                                      longint tx, longint ty);
    longint sx, sy, ox, oy, mx, my;
    sx = pen_x;
    sy = pen_y;
    ox = halve(sx, tx);
    oy = halve(sy, ty);
    mx = halve(ox, cx);
    my = halve(oy, cy);
    if (d >= split_cap || (mx == ox && my == oy)) begin
      draw_to(tx, ty);
      return;
    end
    split_conic(d + 1, halve(sx, cx), halve(sy, cy), mx, my);
    split_conic(d + 1, halve(cx, tx), halve(cy, ty), tx, ty);
  endfunction

  function automatic void split_cubic(int unsigned d, longint ax, longint ay,
                                      longint bx, longint by, longint tx, longint ty);
    longint sx, sy, ox, oy, cx, cy, p1x, p1y, q1x, q1y, p2x, p2y, q2x, q2y, mx, my;
    sx = pen_x;
    sy = pen_y;
    ox = halve(sx, tx);
    oy = halve(sy, ty);
    cx = halve(ax, bx);
    cy = halve(ay, by);
    p1x = halve(sx, ax);
    p1y = halve(sy, ay);
    q1x = halve(tx, bx);
    q1y = halve(ty, by);
    p2x = halve(p1x, cx);
    p2y = halve(p1y, cy);
    q2x = halve(q1x, cx);
    q2y = halve(q1y, cy);
    mx = halve(p2x, q2x);
    my = halve(p2y, q2y);
    if (d >= split_cap || (mx == ox && my == oy)) begin
      draw_to(tx, ty);
      return;
    end
    split_cubic(d + 1, p1x, p1y, p2x, p2y, mx, my);
    split_cubic(d + 1, q2x, q2y, q1x, q1y, tx, ty);
  endfunction

  function automatic void unit_of(longint x, longint y, output longint ux, output longint uy);
    longint unsigned len;
    longint a, b;
    len = root64(longint'(x * x + y * y) << 16);
    a = quot_trunc(x * 16777216, len);
    b = quot_trunc(y * 16777216, len);
    ux = a > UNIT_ONE ? UNIT_ONE : (a < -UNIT_ONE ? -UNIT_ONE : a);
    uy = b > UNIT_ONE ? UNIT_ONE : (b < -UNIT_ONE ? -UNIT_ONE : b);
  endfunction

  function automatic longint arc_point(longint c, longint k, longint v);
    return clip16(quot_trunc(c * UNIT_ONE + k * v, UNIT_ONE));
  endfunction

  function automatic void split_arc(int unsigned d, longint cx, longint cy,
                                    longint tx, longint ty);
    longint sx, sy, ax, ay, bx, by, uax, uay, ubx, uby, vx, vy, k, mx, my;
    longint unsigned vv, r, four;
    longint hx, hy;
    sx = pen_x;
    sy = pen_y;
    ax = sx - cx;
    ay = sy - cy;
    bx = tx - cx;
    by = ty - cy;
    four = 64'd4 << 32;
    if (d >= split_cap || (ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      draw_to(tx, ty);
      return;
    end
    unit_of(ax, ay, uax, uay);
    unit_of(bx, by, ubx, uby);
    vx = uax + ubx;
    vy = uay + uby;
    vv = vx * vx + vy * vy;
    if (vv == 0) begin
      draw_to(tx, ty);
      return;
    end
    r = root64(vv >= four ? 0 : four - vv);
    k = longint'((64'd1 << 32) / (64'd131072 + r));
    mx = arc_point(cx, k, ax + bx);
    my = arc_point(cy, k, ay + by);
    if (mx == halve(sx, tx) && my == halve(sy, ty)) begin
      draw_to(tx, ty);
      return;
    end
    hx = arc_point(cx, 2 * k, bx);
    hy = arc_point(cy, 2 * k, by);
    split_arc(d + 1, arc_point(cx, 2 * k, ax), arc_point(cy, 2 * k, ay), mx, my);
    split_arc(d + 1, hx, hy, tx, ty);
  endfunction

  function automatic void flatten_cmd(logic [CMD_W-1:0] cmd, longint x1, longint y1,
                                      longint x2, longint y2, longint x3, longint y3);
    cmd_segs.delete();
    split_cap = depth_reg < DEPTH_CAP ? depth_reg : DEPTH_CAP;
    case (cmd)
      CMD_MOVE: begin
        push_seg(KIND_OPEN, x1, y1);
        pen_x = x1;
        pen_y = y1;
        sub_x = x1;
        sub_y = y1;
      end
      CMD_LINE: draw_to(x1, y1);
      CMD_CONIC: split_conic(0, x1, y1, x2, y2);
      CMD_ARC: split_arc(0, x1, y1, x2, y2);
      CMD_CUBIC: split_cubic(0, x1, y1, x2, y2, x3, y3);
      CMD_CLOSE: begin
        push_seg(KIND_CLOSE, sub_x, sub_y);
        pen_x = sub_x;
        pen_y = sub_y;
      end
      default: push_seg(KIND_ERROR, 0, 0);
    endcase
    cmd_segs[cmd_segs.size() - 1].last = 1'b1;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input shortint x1, input shortint y1,
                          input shortint x2, input shortint y2, input shortint x3,
                          input shortint y3, input bit typed, input seg_t typed_seg);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid = 1'b1;
    cmd_bus.command = cmd;
    cmd_bus.x1 = x1;
    cmd_bus.y1 = y1;
    cmd_bus.x2 = x2;
    cmd_bus.y2 = y2;
    cmd_bus.x3 = x3;
    cmd_bus.y3 = y3;
    do @(posedge clk); while (!(cmd_bus.valid && cmd_bus.ready));
    flatten_cmd(cmd, x1, y1, x2, y2, x3, y3);
    if (typed) begin
      cmd_segs.delete();
      cmd_segs.push_back(typed_seg);
    end
    foreach (cmd_segs[i]) seg_expect.push_back(cmd_segs[i]);
    cmd_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_bus.valid = 1'b0;
    while (seg_expect.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_depth(input int unsigned value);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = CFG_ADDR_W'(4 * REG_MAX_DEPTH);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[DEPTH_W-1:0] != value[DEPTH_W-1:0])
      report($sformatf("max_depth read %0d, wrote %0d", prdata[DEPTH_W-1:0], value));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    depth_reg = value & 7;
  endtask

  function automatic shortint near(longint base);
    return shortint'(clip16(base + longint'($urandom_range(400)) - 200));
  endfunction

  task automatic random_cmd();
    int unsigned pick;
    logic [CMD_W-1:0] cmd;
    shortint p[6];
    bit local_pts;
    pick = $urandom_range(99);
    cmd = pick < 10 ? CMD_MOVE : pick < 25 ? CMD_LINE : pick < 45 ? CMD_CONIC :
          pick < 60 ? CMD_ARC : pick < 82 ? CMD_CUBIC : pick < 94 ? CMD_CLOSE :
          (pick[0] ? CMD_BAD_LO : CMD_BAD_HI);
    local_pts = $urandom_range(99) < (cmd == CMD_ARC ? 80 : 55);
    foreach (p[i])
      p[i] = local_pts ? near(i[0] ? pen_y : pen_x) : shortint'($urandom());
    send_cmd(cmd, p[0], p[1], p[2], p[3], p[4], p[5], 1'b0, '0);
  endtask

  always @(negedge clk) begin
    seg_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    seg_t got, want;
    if (rst_n && seg_bus.valid && seg_bus.ready) begin
      got = '{seg_bus.kind, seg_bus.x, seg_bus.y, seg_bus.last};
      seg_count++;
      if (seg_expect.size() == 0) begin
        report($sformatf("unexpected transfer kind %0d (%0d,%0d)", got.kind, got.x, got.y));
      end else begin
        want = seg_expect.pop_front();
        if (got.kind != want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.x != want.x) report($sformatf("x %0d, want %0d", got.x, want.x));
        if (got.y != want.y) report($sformatf("y %0d, want %0d", got.y, want.y));
        if (got.last != want.last)
          report($sformatf("last %0d, want %0d", got.last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (seg_bus.valid && seg_bus.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{CMD_CLOSE, 0, 0, 0, 0, 0, 0, 1, KIND_CLOSE, 0, 0},
    '{CMD_MOVE, -32768, 32767, 5, 5, 5, 5, 1, KIND_OPEN, -32768, 32767},
    '{CMD_LINE, 32767, -32768, -1, -1, -1, -1, 1, KIND_LINE, 32767, -32768},
    '{CMD_CLOSE, 9, 9, 9, 9, 9, 9, 1, KIND_CLOSE, -32768, 32767},
    '{CMD_BAD_LO, -1, -1, -1, -1, -1, -1, 1, KIND_ERROR, 0, 0},
    '{CMD_BAD_HI, 0, 0, 0, 0, 0, 0, 1, KIND_ERROR, 0, 0},
    '{CMD_MOVE, 0, 0, 0, 0, 0, 0, 1, KIND_OPEN, 0, 0},
    '{CMD_CONIC, 100, 200, 300, 0, 0, 0, 0, KIND_LINE, 0, 0},
    '{CMD_CUBIC, 300, 300, 600, -300, 900, 0, 0, KIND_LINE, 0, 0},
    '{CMD_MOVE, 0, 0, 0, 0, 0, 0, 1, KIND_OPEN, 0, 0},
    '{CMD_ARC, 1000, 0, 1000, 1000, 0, 0, 0, KIND_LINE, 0, 0},
    '{CMD_ARC, 1000, 1000, 50, 50, 0, 0, 1, KIND_LINE, 50, 50},
    '{CMD_ARC, 70, 70, 70, 70, 0, 0, 1, KIND_LINE, 70, 70},
    '{CMD_MOVE, 0, 0, 0, 0, 0, 0, 1, KIND_OPEN, 0, 0},
    '{CMD_ARC, 100, 0, 200, 0, 0, 0, 1, KIND_LINE, 200, 0},
    '{CMD_CONIC, 32767, 32767, -32768, -32768, 0, 0, 0, KIND_LINE, 0, 0},
    '{CMD_CUBIC, -32768, 32767, 32767, -32768, 32767, 32767, 0, KIND_LINE, 0, 0},
    '{CMD_ARC, 32767, -32768, -32768, -32768, 0, 0, 0, KIND_LINE, 0, 0},
    '{CMD_CONIC, -32768, -32768, -32768, -32768, 0, 0, 0, KIND_LINE, 0, 0},
    '{CMD_CLOSE, 0, 0, 0, 0, 0, 0, 1, KIND_CLOSE, 0, 0}
  };

  int unsigned depth_plan[5] = '{0, 7, 3, 6, 1};
  int idle_plan[5] = '{0, 79, 0, 7, 0};
  int stall_plan[5] = '{0, 0, 79, 7, 0};

  initial begin
    seg_t typed_seg;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CMD_MOVE;
    {cmd_bus.x1, cmd_bus.y1, cmd_bus.x2, cmd_bus.y2, cmd_bus.x3, cmd_bus.y3} = '0;
    seg_bus.ready = 1'b0;
    fail_count = 0;
    cmd_count = 0;
    seg_count = 0;
    quiet = 0;
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    pen_x = 0;
    pen_y = 0;
    sub_x = 0;
    sub_y = 0;
    depth_reg = MAX_DEPTH_RESET;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      typed_seg = '{dir_rows[i].kind, dir_rows[i].ex, dir_rows[i].ey, 1'b1};
      send_cmd(dir_rows[i].cmd, dir_rows[i].x1, dir_rows[i].y1, dir_rows[i].x2,
               dir_rows[i].y2, dir_rows[i].x3, dir_rows[i].y3, dir_rows[i].typed, typed_seg);
    end
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_depth(depth_plan[ph]);
      sender_idle_pct = idle_plan[ph];
      sink_stall_pct = stall_plan[ph];
      for (int n = 0; n < 42; n++) random_cmd();
    end
    drain();
    $display("covered %0d commands and %0d segment transfers", cmd_count, seg_count);
    $display("depth caps 6,0,7,3,6,1 with sender idling and receiver stalls");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
